// File: sv/mrfe_pkg.sv
`default_nettype none
package mrfe_pkg;

    localparam int SCREEN_WIDTH_DEF   = 640;
    localparam int SCREEN_HEIGHT_DEF  = 200;
    localparam int ODD_PLANE_BASE_DEF = 8192;

    localparam int ADDR_W = 14;     // byte store address
    localparam int COL_W  = 12;     // pixel column incl. outline border and sums
    localparam int ROW_W  = 10;     // pixel row incl. sums
    localparam int BIDX_W = COL_W - 3;

    localparam logic [7:0] GRAY_EVEN_RST = 8'h55;
    localparam logic [7:0] GRAY_ODD_RST  = 8'hAA;
    localparam logic [7:0] PAT_BLACK     = 8'h00;
    localparam logic [7:0] PAT_WHITE     = 8'hFF;

    localparam logic [1:0] K_READ    = 2'd0;
    localparam logic [1:0] K_LINE    = 2'd1;
    localparam logic [1:0] K_OUTLINE = 2'd2;
    localparam logic [1:0] K_FILL    = 2'd3;

    localparam logic [1:0] BR_BLACK = 2'd0;
    localparam logic [1:0] BR_WHITE = 2'd1;
    localparam logic [1:0] BR_GRAY  = 2'd2;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_OUTSIDE    = 2'd1;
    localparam logic [1:0] ST_BAD_HEIGHT = 2'd2;

    localparam logic CFG_GRAY_EVEN = 1'b0;
    localparam logic CFG_GRAY_ODD  = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  pos_x;
        logic [7:0]  pos_y;
        logic [9:0]  span_width;
        logic [7:0]  span_height;
        logic [1:0]  brush;
        logic [13:0] read_address;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
    } t_result;

    typedef enum logic [2:0] {
        SP_FULL  = 3'd0,
        SP_TOP   = 3'd1,
        SP_BOT   = 3'd2,
        SP_LEFT  = 3'd3,
        SP_RIGHT = 3'd4
    } t_span;

    typedef struct packed {
        logic  latch;
        logic  clr_step;
        logic  span_ld;
        t_span sel;
        logic  rd_mem;
        logic  wr_mem;
        logic  fetch;
        logic  next_byte;
        logic  next_row;
    } t_dp_ctl;

    typedef struct packed {
        logic [1:0] kind;
        logic       failed;
        logic       h_zero;
        logic       span_empty;
        logic       last_byte;
        logic       last_row;
        logic       clear_done;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: sv/mrfe_dp.sv
`default_nettype none
module mrfe_dp #(
    parameter int SCREEN_WIDTH   = mrfe_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT  = mrfe_pkg::SCREEN_HEIGHT_DEF,
    parameter int ODD_PLANE_BASE = mrfe_pkg::ODD_PLANE_BASE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mrfe_pkg::t_cmd    i_cmd,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [7:0]        i_cfg_data,
    input  wire mrfe_pkg::t_dp_ctl i_ctl,
    output mrfe_pkg::t_dp_stat     o_stat,
    output mrfe_pkg::t_result      o_result
);
    import mrfe_pkg::*;

    localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
    localparam int DEPTH     = 2 ** ADDR_W;

    logic [7:0] mem [DEPTH];

    logic [7:0]        r_gray_even, r_gray_odd;
    t_cmd              r_cmd;
    logic [1:0]        r_status;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_left, r_right;
    logic [BIDX_W-1:0] r_b, r_b_end;
    logic [ADDR_W-1:0] r_base, r_clr;
    logic [7:0]        r_pat, r_rdata;

    // request checks on the incoming command
    logic [COL_W-1:0] in_xw;
    logic [ROW_W-1:0] in_yh;
    logic [1:0]       n_status;

    always_comb begin
        in_xw = COL_W'(i_cmd.pos_x) + COL_W'(i_cmd.span_width);
        in_yh = ROW_W'(i_cmd.pos_y) + ROW_W'(i_cmd.span_height);
        n_status = ST_DONE;
        case (i_cmd.kind)
            K_LINE: begin
                if (i_cmd.span_height != 8'd1)
                    n_status = ST_BAD_HEIGHT;
                else if (in_xw > COL_W'(SCREEN_WIDTH)
                         || ROW_W'(i_cmd.pos_y) >= ROW_W'(SCREEN_HEIGHT))
                    n_status = ST_OUTSIDE;
            end
            K_OUTLINE: begin
                if (i_cmd.pos_x == 10'd0 || i_cmd.pos_y == 8'd0
                    || in_xw + COL_W'(1) > COL_W'(SCREEN_WIDTH)
                    || in_yh + ROW_W'(1) > ROW_W'(SCREEN_HEIGHT))
                    n_status = ST_OUTSIDE;
            end
            K_FILL: begin
                if (in_xw > COL_W'(SCREEN_WIDTH) || in_yh > ROW_W'(SCREEN_HEIGHT))
                    n_status = ST_OUTSIDE;
            end
            default: n_status = ST_DONE;
        endcase
    end

    // span of the current request step
    logic [COL_W-1:0]  x, xw, sp_left, sp_right, sp_rm1;
    logic [ROW_W-1:0]  y, yh, sp_row;
    logic [7:0]        sp_pat;
    logic [ADDR_W+8:0] sp_base;

    always_comb begin
        x  = COL_W'(r_cmd.pos_x);
        xw = x + COL_W'(r_cmd.span_width);
        y  = ROW_W'(r_cmd.pos_y);
        yh = y + ROW_W'(r_cmd.span_height);
        sp_row   = r_row;
        sp_left  = x;
        sp_right = xw;
        case (i_ctl.sel)
            SP_TOP: begin
                sp_row   = y - ROW_W'(1);
                sp_left  = x - COL_W'(1);
                sp_right = xw + COL_W'(1);
            end
            SP_BOT: begin
                sp_row   = yh;
                sp_left  = x - COL_W'(1);
                sp_right = xw + COL_W'(1);
            end
            SP_LEFT: begin
                sp_left  = x - COL_W'(1);
                sp_right = x;
            end
            SP_RIGHT: begin
                sp_left  = xw;
                sp_right = xw + COL_W'(1);
            end
            default: begin
                sp_left  = x;
                sp_right = xw;
            end
        endcase
        sp_rm1 = sp_right - COL_W'(1);
        case (r_cmd.brush)
            BR_BLACK: sp_pat = PAT_BLACK;
            BR_GRAY:  sp_pat = sp_row[0] ? r_gray_odd : r_gray_even;
            default:  sp_pat = PAT_WHITE;
        endcase
        sp_base = (ADDR_W+9)'(sp_row >> 1) * (ADDR_W+9)'(ROW_BYTES)
                  + (sp_row[0] ? (ADDR_W+9)'(ODD_PLANE_BASE) : '0);
    end

    // edge mask of the current byte
    logic [COL_W-1:0] b_start, lo_d, hi_d;
    logic [3:0]       lo, hi;
    logic [7:0]       mask;

    always_comb begin
        b_start = {r_b, 3'b000};
        lo_d = r_left - b_start;
        hi_d = r_right - b_start;
        lo = (r_left > b_start) ? lo_d[3:0] : 4'd0;
        hi = (r_right < b_start + COL_W'(8)) ? hi_d[3:0] : 4'd8;
        mask = (8'hFF >> lo) & ~(8'hFF >> hi);
    end

    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;

    always_comb begin
        addr = r_base + ADDR_W'(r_b);
        if (i_ctl.clr_step)
            addr = r_clr;
        else if (i_ctl.fetch)
            addr = r_cmd.read_address;
        wdata = i_ctl.clr_step ? 8'h00 : ((r_rdata & ~mask) | (r_pat & mask));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step || i_ctl.wr_mem)
            mem[addr] <= wdata;
        if (i_ctl.rd_mem || i_ctl.fetch)
            r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_even <= GRAY_EVEN_RST;
            r_gray_odd  <= GRAY_ODD_RST;
            r_clr       <= '0;
            r_status    <= ST_DONE;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_GRAY_EVEN)
                r_gray_even <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_GRAY_ODD)
                r_gray_odd <= i_cfg_data;
            if (i_ctl.clr_step)
                r_clr <= r_clr + ADDR_W'(1);
            if (i_ctl.latch)
                r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd <= i_cmd;
            r_row <= ROW_W'(i_cmd.pos_y);
        end
        if (i_ctl.next_row)
            r_row <= r_row + ROW_W'(1);
        if (i_ctl.span_ld) begin
            r_left  <= sp_left;
            r_right <= sp_right;
            r_b     <= sp_left[COL_W-1:3];
            r_b_end <= sp_rm1[COL_W-1:3];
            r_base  <= sp_base[ADDR_W-1:0];
            r_pat   <= sp_pat;
        end
        if (i_ctl.next_byte)
            r_b <= r_b + BIDX_W'(1);
    end

    always_comb begin
        o_stat.kind       = r_cmd.kind;
        o_stat.failed     = (r_status != ST_DONE);
        o_stat.h_zero     = (r_cmd.span_height == 8'd0);
        o_stat.span_empty = (sp_left >= sp_right);
        o_stat.last_byte  = (r_b == r_b_end);
        o_stat.last_row   = (r_row + ROW_W'(1) == yh);
        o_stat.clear_done = (r_clr == {ADDR_W{1'b1}});
        o_result.read_data = (r_cmd.kind == K_READ) ? r_rdata : 8'h00;
        o_result.status    = r_status;
    end

endmodule
`default_nettype wire

// File: sv/mrfe_ctrl.sv
`default_nettype none
module mrfe_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire mrfe_pkg::t_dp_stat i_stat,
    output mrfe_pkg::t_dp_ctl       o_ctl,
    output logic                    busy,
    output logic                    o_done
);
    import mrfe_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_CHECK = 9'b000000100,
        S_SPAN  = 9'b000001000,
        S_RD    = 9'b000010000,
        S_WR    = 9'b000100000,
        S_NEXT  = 9'b001000000,
        S_FETCH = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_span  r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_ctl   = '0;
        o_ctl.sel = r_sel;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_stat.clear_done)
                    n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_ctl.latch = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.kind == K_READ) begin
                    n_state = S_FETCH;
                end else if (i_stat.failed) begin
                    n_state = S_DONE;
                end else if (i_stat.kind == K_OUTLINE) begin
                    n_sel   = SP_TOP;
                    n_state = S_SPAN;
                end else if (i_stat.h_zero) begin
                    n_state = S_DONE;
                end else begin
                    // a line is a fill one row high
                    n_sel   = SP_FULL;
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                o_ctl.span_ld = 1'b1;
                n_state = i_stat.span_empty ? S_NEXT : S_RD;
            end
            S_RD: begin
                o_ctl.rd_mem = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_ctl.wr_mem = 1'b1;
                if (i_stat.last_byte) begin
                    n_state = S_NEXT;
                end else begin
                    o_ctl.next_byte = 1'b1;
                    n_state = S_RD;
                end
            end
            S_NEXT: begin
                n_state = S_SPAN;
                case (r_sel)
                    SP_TOP: n_sel = SP_BOT;
                    SP_BOT: begin
                        if (i_stat.h_zero)
                            n_state = S_DONE;
                        else
                            n_sel = SP_LEFT;
                    end
                    SP_LEFT: n_sel = SP_RIGHT;
                    SP_RIGHT: begin
                        if (i_stat.last_row) begin
                            n_state = S_DONE;
                        end else begin
                            o_ctl.next_row = 1'b1;
                            n_sel = SP_LEFT;
                        end
                    end
                    default: begin
                        if (i_stat.last_row)
                            n_state = S_DONE;
                        else
                            o_ctl.next_row = 1'b1;
                    end
                endcase
            end
            S_FETCH: begin
                o_ctl.fetch = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sel   <= SP_FULL;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> $past(r_state == S_RD))
        else $error("byte write without read");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("result strobe longer than one cycle");

    a_start_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start) |=> (r_state == S_CHECK))
        else $error("request not taken");

    a_no_clear_later: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("clearing pass re-entered");

endmodule
`default_nettype wire

// File: sv/mono_raster_fill_engine_top.sv
`default_nettype none
// channel   ports                                   handshake
// request   i_cmd (kind, pos, span, brush, addr)    start && !busy
// result    o_result (read_data, status)            o_done, one cycle
// config    i_cfg_index, i_cfg_data                 i_cfg_we
//
// After reset the frame store is cleared, one byte a cycle, with busy high.
// Read request: S_CHECK, S_FETCH, then S_DONE raises o_done; the next start is taken
// in the cycle after. Draw request: each painted byte is a read then a merge write
// (S_RD, S_WR) on the single store port; each span adds S_SPAN and S_NEXT; outline sides
// take 2 spans a row. Rejected requests skip to S_DONE. The result cannot be held off.
module mono_raster_fill_engine_top #(
    parameter int SCREEN_WIDTH   = mrfe_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT  = mrfe_pkg::SCREEN_HEIGHT_DEF,
    parameter int ODD_PLANE_BASE = mrfe_pkg::ODD_PLANE_BASE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mrfe_pkg::t_cmd    i_cmd,
    output logic                   o_done,
    output mrfe_pkg::t_result      o_result,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [7:0]        i_cfg_data
);
    import mrfe_pkg::*;

    t_dp_ctl  ctl;
    t_dp_stat stat;

    mrfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .busy    (busy),
        .o_done  (o_done)
    );

    mrfe_dp #(
        .SCREEN_WIDTH   (SCREEN_WIDTH),
        .SCREEN_HEIGHT  (SCREEN_HEIGHT),
        .ODD_PLANE_BASE (ODD_PLANE_BASE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mrfe_pkg::*;

    localparam int ROW_BYTES  = 80;
    localparam int STALL_LIMIT = 200000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_cmd       i_cmd = '0;
    logic       o_done;
    t_result    o_result;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = CFG_GRAY_EVEN;
    logic [7:0] i_cfg_data = '0;

    mono_raster_fill_engine_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_done(o_done), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // shadow of the frame store and brush registers
    logic [7:0] frame_model [16384];
    logic [7:0] gray_even = GRAY_EVEN_RST;
    logic [7:0] gray_odd  = GRAY_ODD_RST;
    t_result    pending_results [$];
    int         mismatches = 0;
    bit         no_gaps = 1'b0;

    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result res;
    } t_dir_row;
    t_dir_row dir_rows [$];

    function automatic logic [7:0] brush_pattern(logic [1:0] br, int row);
        if (br == BR_BLACK) return PAT_BLACK;
        if (br == BR_GRAY) return row[0] ? gray_odd : gray_even;
        return PAT_WHITE;   // white, and the unused code
    endfunction

    function automatic void paint_row(int row, int left, int right, logic [7:0] pat);
        int base, b, lo, hi, m, a;
        if (left >= right) return;
        base = (row[0] ? ODD_PLANE_BASE_DEF : 0) + (row >> 1) * ROW_BYTES;
        for (b = left >> 3; b <= (right - 1) >> 3; b++) begin
            lo = (left > b * 8) ? left - b * 8 : 0;
            hi = (right < b * 8 + 8) ? right - b * 8 : 8;
            m  = (255 >> lo) & ~(255 >> hi) & 255;
            a  = (base + b) & 16383;
            frame_model[a] = (frame_model[a] & ~m[7:0]) | (pat & m[7:0]);
        end
    endfunction

    function automatic t_result predict_command(t_cmd c);
        t_result r;
        int x, y, w, h, r_i;
        x = c.pos_x; y = c.pos_y; w = c.span_width; h = c.span_height;
        r.read_data = 8'h00;
        r.status    = ST_DONE;
        case (c.kind)
            K_READ: r.read_data = frame_model[c.read_address];
            K_LINE: begin
                if (h != 1) r.status = ST_BAD_HEIGHT;
                else if (x + w > SCREEN_WIDTH_DEF || y >= SCREEN_HEIGHT_DEF)
                    r.status = ST_OUTSIDE;
                else paint_row(y, x, x + w, brush_pattern(c.brush, y));
            end
            K_OUTLINE: begin
                if (x == 0 || y == 0 || x + w + 1 > SCREEN_WIDTH_DEF ||
                    y + h + 1 > SCREEN_HEIGHT_DEF) begin
                    r.status = ST_OUTSIDE;
                end else begin
                    paint_row(y - 1, x - 1, x + w + 1, brush_pattern(c.brush, y - 1));
                    paint_row(y + h, x - 1, x + w + 1, brush_pattern(c.brush, y + h));
                    for (r_i = y; r_i < y + h; r_i++) begin
                        paint_row(r_i, x - 1, x, brush_pattern(c.brush, r_i));
                        paint_row(r_i, x + w, x + w + 1, brush_pattern(c.brush, r_i));
                    end
                end
            end
            default: begin
                if (x + w > SCREEN_WIDTH_DEF || y + h > SCREEN_HEIGHT_DEF)
                    r.status = ST_OUTSIDE;
                else
                    for (r_i = y; r_i < y + h; r_i++)
                        paint_row(r_i, x, x + w, brush_pattern(c.brush, r_i));
            end
        endcase
        return r;
    endfunction

    function automatic t_cmd mk_cmd(logic [1:0] k, int x, int y, int w, int h,
                                    logic [1:0] br, int addr);
        t_cmd c;
        c.kind = k; c.pos_x = 10'(x); c.pos_y = 8'(y); c.span_width = 10'(w);
        c.span_height = 8'(h); c.brush = br; c.read_address = 14'(addr);
        return c;
    endfunction

    function automatic void add_row(t_cmd c, bit typed, logic [7:0] rd, logic [1:0] st);
        t_dir_row d;
        d.cmd = c; d.typed = typed; d.res.read_data = rd; d.res.status = st;
        dir_rows.push_back(d);
    endfunction

    function automatic t_cmd random_command();
        t_cmd c;
        int sel, w, h;
        logic [63:0] rnd;
        sel = $urandom_range(0, 999);
        c = mk_cmd(K_READ, 0, 0, 0, 0, BR_BLACK, 0);
        if (sel < 250) begin
            rnd = {$urandom, $urandom};
            c = rnd[$bits(t_cmd)-1:0];
            c.kind = K_READ;
            // half the time near the painted area, else anywhere
            if ($urandom_range(0, 1))
                c.read_address = 14'(($urandom_range(0, 1) ? ODD_PLANE_BASE_DEF : 0)
                                     + $urandom_range(0, 8 * ROW_BYTES));
        end else if (sel < 400) begin
            rnd = {$urandom, $urandom};     // noise, mostly rejected
            c = rnd[$bits(t_cmd)-1:0];
        end else if (sel < 405) begin
            h = $urandom_range(100, 200);
            c = mk_cmd($urandom_range(0, 1) ? K_FILL : K_OUTLINE, $urandom_range(1, 8),
                       $urandom_range(1, 200 - h), $urandom_range(560, 630), h - 1,
                       2'($urandom_range(0, 3)), $urandom);
        end else begin
            w = $urandom_range(0, 40);
            h = $urandom_range(0, 8);
            c.kind = 2'($urandom_range(1, 3));
            if (c.kind == K_LINE && $urandom_range(0, 7) != 0) h = 1;
            c.pos_x = 10'($urandom_range(0, 1) ? $urandom_range(1, 40)
                                               : $urandom_range(1, 598));
            c.pos_y = 8'($urandom_range(0, 1) ? $urandom_range(1, 8)
                                              : $urandom_range(1, 190));
            c.span_width = 10'(w);
            c.span_height = 8'(h);
            c.brush = 2'($urandom_range(0, 3));
            c.read_address = 14'($urandom);
        end
        return c;
    endfunction

    task automatic issue_request(t_cmd c, bit typed, t_result res);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0 && start) start <= 1'b0;
        repeat (gap) @(posedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        if (typed) begin
            void'(predict_command(c));
            pending_results.push_back(res);
        end else begin
            pending_results.push_back(predict_command(c));
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_grays(logic [7:0] ev, logic [7:0] od);
        i_cfg_we <= 1'b1; i_cfg_index <= CFG_GRAY_EVEN; i_cfg_data <= ev;
        @(posedge i_clk);
        i_cfg_index <= CFG_GRAY_ODD; i_cfg_data <= od;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gray_even = ev;
        gray_odd  = od;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result rd=%02h st=%0d",
                             o_result.read_data, o_result.status);
            end else begin
                want = pending_results.pop_front();
                if (o_result.read_data !== want.read_data ||
                    o_result.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp rd=%02h st=%0d, got rd=%02h st=%0d",
                                 want.read_data, want.status,
                                 o_result.read_data, o_result.status);
                end
            end
        end
    end

    // stall watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** mono_raster_fill_engine_top: FAILED **");
            $finish;
        end
    end

    initial begin
        t_result none;
        int ph, n;
        none = '0;
        foreach (frame_model[i]) frame_model[i] = 8'h00;

        add_row(mk_cmd(K_READ, 0, 0, 0, 0, BR_BLACK, 0), 1, 8'h00, ST_DONE);
        add_row(mk_cmd(K_READ, 0, 0, 0, 0, BR_BLACK, 16383), 1, 8'h00, ST_DONE);
        add_row(mk_cmd(K_LINE, 0, 0, 8, 0, BR_WHITE, 0), 1, 8'h00, ST_BAD_HEIGHT);
        add_row(mk_cmd(K_LINE, 0, 0, 8, 255, BR_WHITE, 0), 1, 8'h00, ST_BAD_HEIGHT);
        add_row(mk_cmd(K_LINE, 639, 0, 2, 1, BR_WHITE, 0), 1, 8'h00, ST_OUTSIDE);
        add_row(mk_cmd(K_LINE, 0, 200, 1, 1, BR_WHITE, 0), 1, 8'h00, ST_OUTSIDE);
        add_row(mk_cmd(K_LINE, 640, 199, 0, 1, BR_WHITE, 0), 1, 8'h00, ST_DONE);
        add_row(mk_cmd(K_FILL, 640, 200, 0, 0, BR_WHITE, 0), 1, 8'h00, ST_DONE);
        add_row(mk_cmd(K_FILL, 1023, 255, 1023, 255, BR_WHITE, 0), 1, 8'h00, ST_OUTSIDE);
        add_row(mk_cmd(K_OUTLINE, 0, 5, 4, 4, BR_WHITE, 0), 1, 8'h00, ST_OUTSIDE);
        add_row(mk_cmd(K_OUTLINE, 5, 0, 4, 4, BR_WHITE, 0), 1, 8'h00, ST_OUTSIDE);
        add_row(mk_cmd(K_OUTLINE, 1, 1, 639, 1, BR_WHITE, 0), 1, 8'h00, ST_OUTSIDE);
        // span inside one byte, masked both ends
        add_row(mk_cmd(K_LINE, 3, 0, 2, 1, BR_WHITE, 0), 0, 0, 0);
        add_row(mk_cmd(K_READ, 0, 0, 0, 0, BR_BLACK, 0), 0, 0, 0);
        add_row(mk_cmd(K_FILL, 0, 0, 640, 200, BR_GRAY, 0), 0, 0, 0);
        add_row(mk_cmd(K_READ, 0, 0, 0, 0, BR_BLACK, 8192), 0, 0, 0);
        add_row(mk_cmd(K_OUTLINE, 1, 1, 638, 198, 2'd3, 0), 0, 0, 0);
        add_row(mk_cmd(K_READ, 0, 0, 0, 0, BR_BLACK, 8192 + 99 * 80 + 79), 0, 0, 0);
        add_row(mk_cmd(K_FILL, 9, 2, 13, 3, BR_BLACK, 0), 0, 0, 0);
        add_row(mk_cmd(K_OUTLINE, 20, 10, 0, 0, BR_BLACK, 0), 0, 0, 0);
        add_row(mk_cmd(K_LINE, 632, 199, 8, 1, BR_BLACK, 0), 0, 0, 0);
        add_row(mk_cmd(K_READ, 0, 0, 0, 0, BR_BLACK, 8192 + 99 * 80 + 79), 0, 0, 0);
        add_row(mk_cmd(K_READ, 0, 0, 0, 0, BR_BLACK, 80 + 1), 0, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);   // store clear after reset

        foreach (dir_rows[i]) issue_request(dir_rows[i].cmd, dir_rows[i].typed,
                                            dir_rows[i].res);

        for (ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: set_grays(8'h00, 8'hFF);
                1: set_grays(8'hFF, 8'h00);
                2: set_grays(8'($urandom), 8'($urandom));
                default: set_grays(GRAY_EVEN_RST, GRAY_ODD_RST);
            endcase
            for (n = 0; n < 240; n++) begin
                if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                issue_request(random_command(), 0, none);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("** mono_raster_fill_engine_top: PASSED **");
        end else begin
            $display("** mono_raster_fill_engine_top: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
